[design/ubxfp_pkg.sv]
// ============================================================================
// ubxfp_pkg
// Shared types and constants for the binary receiver frame parser.
// ============================================================================
`default_nettype none

package ubxfp_pkg;

    // Frame layout
    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [7:0]  NAV_CLASS   = 8'h01;
    localparam logic [7:0]  NAV_ID      = 8'h07;
    localparam logic [15:0] NAV_MIN_LEN = 16'd78;
    localparam logic [7:0]  FIX_KIND_MIN = 8'd2;

    // Payload capacity; longer frames are skipped
    localparam int          MAX_PAYLOAD_VAL = 128;
    localparam logic [16:0] MAX_PAYLOAD     = 17'(MAX_PAYLOAD_VAL);

    // Position counter covers payload offsets and the skip count (length + 2)
    localparam int POS_W = 17;

    // Payload offsets of captured fields
    localparam logic [POS_W-1:0] OFS_KIND   = 17'd20;
    localparam logic [POS_W-1:0] OFS_FLAGS  = 17'd21;
    localparam logic [POS_W-1:0] OFS_SATS   = 17'd23;
    localparam logic [POS_W-1:0] OFS_LON    = 17'd24;
    localparam logic [POS_W-1:0] OFS_LAT    = 17'd28;
    localparam logic [POS_W-1:0] OFS_HEIGHT = 17'd36;
    localparam logic [POS_W-1:0] OFS_SPEED  = 17'd60;
    localparam logic [POS_W-1:0] OFS_HEAD   = 17'd64;
    localparam logic [POS_W-1:0] OFS_DIL_LO = 17'd76;
    localparam logic [POS_W-1:0] OFS_DIL_HI = 17'd77;

    // Captured 32-bit words: longitude, latitude, height, speed, heading
    localparam int CAP_WORDS = 5;
    localparam int CAP_IDX_W = $clog2(CAP_WORDS);
    localparam logic [CAP_IDX_W-1:0] CAP_LON    = CAP_IDX_W'(0);
    localparam logic [CAP_IDX_W-1:0] CAP_LAT    = CAP_IDX_W'(1);
    localparam logic [CAP_IDX_W-1:0] CAP_HEIGHT = CAP_IDX_W'(2);
    localparam logic [CAP_IDX_W-1:0] CAP_SPEED  = CAP_IDX_W'(3);
    localparam logic [CAP_IDX_W-1:0] CAP_HEAD   = CAP_IDX_W'(4);

    // Result queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_CLASS,
        PH_ID,
        PH_LEN1,
        PH_LEN2,
        PH_PAYLOAD,
        PH_CKA,
        PH_CKB,
        PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_NAV      = 2'd1,
        ST_CKERR    = 2'd2,
        ST_OVERSIZE = 2'd3
    } status_t;

    // One finished frame as handed from parser to output stage
    typedef struct packed {
        status_t                      status;
        logic [7:0]                   msg_class;
        logic [7:0]                   msg_id;
        logic [7:0]                   kind;
        logic                         fix_ok;
        logic [7:0]                   sats;
        logic [CAP_WORDS-1:0][31:0]   cap;
        logic [15:0]                  dilution;
    } frame_rec_t;

    // Queue control handed from the parser to the queue
    typedef struct packed {
        logic push;
        logic full;
    } queue_ctl_t;

endpackage

`default_nettype wire

[design/ubxfp_if.sv]
// ============================================================================
// ubxfp_if
// Valid/ready channels: received bytes in, frame results out.
// ============================================================================
`default_nettype none

interface ubxfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxfp_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [7:0]         msg_class;
    logic [7:0]         msg_id;
    logic               fix_good;
    logic [7:0]         fix_kind;
    logic [7:0]         sat_count;
    logic signed [31:0] longitude_raw;
    logic signed [31:0] latitude_raw;
    logic signed [31:0] height_mm;
    logic signed [31:0] ground_speed_mms;
    logic signed [31:0] heading_raw;
    logic [15:0]        dilution_raw;

    modport source (
        output valid, input ready,
        output frame_status, output msg_class, output msg_id, output fix_good,
        output fix_kind, output sat_count, output longitude_raw,
        output latitude_raw, output height_mm, output ground_speed_mms,
        output heading_raw, output dilution_raw
    );
    modport sink (
        input valid, output ready,
        input frame_status, input msg_class, input msg_id, input fix_good,
        input fix_kind, input sat_count, input longitude_raw,
        input latitude_raw, input height_mm, input ground_speed_mms,
        input heading_raw, input dilution_raw
    );
endinterface

`default_nettype wire

[design/ubxfp_front.sv]
// ============================================================================
// ubxfp_front
// Byte-level frame parser: sync hunt, header, payload capture, checksum and oversize skip.
// ============================================================================
`default_nettype none

module ubxfp_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    ubxfp_byte_if.sink                  rx,
    input  wire logic                   q_full,
    output ubxfp_pkg::queue_ctl_t       q_ctl,
    output ubxfp_pkg::frame_rec_t       q_rec
);
    import ubxfp_pkg::*;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  class_reg, class_next;
    logic [7:0]                  id_reg, id_next;
    logic [15:0]                 len_reg, len_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [7:0]                  sum_a_reg, sum_a_next;
    logic [7:0]                  sum_b_reg, sum_b_next;
    logic [7:0]                  kind_reg, kind_next;
    logic                        fix_ok_reg, fix_ok_next;
    logic [7:0]                  sats_reg, sats_next;
    logic [CAP_WORDS-1:0][31:0]  cap_reg, cap_next;
    logic [15:0]                 dil_reg, dil_next;

    logic                        accept;
    logic [7:0]                  b;
    logic [7:0]                  sum_a_add;
    logic [7:0]                  sum_b_add;
    logic [15:0]                 len_full;
    logic [POS_W-1:0]            pos_inc;
    logic                        cap_hit;
    logic [CAP_IDX_W-1:0]        cap_idx;
    logic                        push;
    status_t                     push_status;

    assign rx.ready  = !q_full;
    assign accept    = rx.valid && rx.ready;
    assign b         = rx.rx_byte;
    assign sum_a_add = sum_a_reg + b;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign len_full  = {b, len_reg[7:0]};
    assign pos_inc   = pos_reg + POS_W'(1);

    // Map payload offset to a captured 32-bit word
    always_comb
    begin
        cap_hit = 1'b1;
        cap_idx = CAP_LON;
        if (pos_reg >= OFS_LON && pos_reg < OFS_LAT)
            cap_idx = CAP_LON;
        else if (pos_reg >= OFS_LAT && pos_reg < OFS_LAT + POS_W'(4))
            cap_idx = CAP_LAT;
        else if (pos_reg >= OFS_HEIGHT && pos_reg < OFS_HEIGHT + POS_W'(4))
            cap_idx = CAP_HEIGHT;
        else if (pos_reg >= OFS_SPEED && pos_reg < OFS_HEAD)
            cap_idx = CAP_SPEED;
        else if (pos_reg >= OFS_HEAD && pos_reg < OFS_HEAD + POS_W'(4))
            cap_idx = CAP_HEAD;
        else
            cap_hit = 1'b0;
    end

    // Advance the parser on each accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        kind_next   = kind_reg;
        fix_ok_next = fix_ok_reg;
        sats_next   = sats_reg;
        cap_next    = cap_reg;
        dil_next    = dil_reg;
        push        = 1'b0;
        push_status = ST_GOOD;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (b == SYNC_FIRST)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    if (b == SYNC_SECOND)
                    begin
                        phase_next = PH_CLASS;
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                    end
                    else if (b != SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_CLASS:
                begin
                    class_next = b;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next    = b;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    len_next   = {8'd0, b};
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = PH_LEN2;
                end
                PH_LEN2:
                begin
                    len_next   = len_full;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    if ({1'b0, len_full} > MAX_PAYLOAD)
                    begin
                        pos_next   = {1'b0, len_full} + POS_W'(2);
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        pos_next   = '0;
                        phase_next = (len_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    // capture navigation fields at their offsets
                    if (pos_reg == OFS_KIND)
                        kind_next = b;
                    if (pos_reg == OFS_FLAGS)
                        fix_ok_next = b[0];
                    if (pos_reg == OFS_SATS)
                        sats_next = b;
                    if (cap_hit)
                        cap_next[cap_idx][{pos_reg[1:0], 3'b000} +: 8] = b;
                    if (pos_reg == OFS_DIL_LO)
                        dil_next[7:0] = b;
                    if (pos_reg == OFS_DIL_HI)
                        dil_next[15:8] = b;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    pos_next   = pos_inc;
                    if (pos_inc >= {1'b0, len_reg})
                        phase_next = PH_CKA;
                end
                PH_CKA:
                begin
                    if (b != sum_a_reg)
                    begin
                        phase_next  = PH_HUNT1;
                        push        = 1'b1;
                        push_status = ST_CKERR;
                    end
                    else
                    begin
                        phase_next = PH_CKB;
                    end
                end
                PH_CKB:
                begin
                    phase_next = PH_HUNT1;
                    push       = 1'b1;
                    if (b != sum_b_reg)
                        push_status = ST_CKERR;
                    else if (class_reg == NAV_CLASS && id_reg == NAV_ID &&
                             len_reg >= NAV_MIN_LEN)
                        push_status = ST_NAV;
                    else
                        push_status = ST_GOOD;
                end
                PH_DISCARD:
                begin
                    // drop bytes until the skip count runs out
                    if (pos_reg <= POS_W'(1))
                    begin
                        pos_next    = '0;
                        phase_next  = PH_HUNT1;
                        push        = 1'b1;
                        push_status = ST_OVERSIZE;
                    end
                    else
                    begin
                        pos_next = pos_reg - POS_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_HUNT1;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        class_reg  <= class_next;
        id_reg     <= id_next;
        len_reg    <= len_next;
        pos_reg    <= pos_next;
        sum_a_reg  <= sum_a_next;
        sum_b_reg  <= sum_b_next;
        kind_reg   <= kind_next;
        fix_ok_reg <= fix_ok_next;
        sats_reg   <= sats_next;
        cap_reg    <= cap_next;
        dil_reg    <= dil_next;
    end

    // Hand the finished frame to the queue
    assign q_ctl.push      = push;
    assign q_ctl.full      = q_full;
    assign q_rec.status    = push_status;
    assign q_rec.msg_class = class_reg;
    assign q_rec.msg_id    = id_reg;
    assign q_rec.kind      = kind_reg;
    assign q_rec.fix_ok    = fix_ok_reg;
    assign q_rec.sats      = sats_reg;
    assign q_rec.cap       = cap_reg;
    assign q_rec.dilution  = dil_reg;

endmodule

`default_nettype wire

[design/ubxfp_queue.sv]
// ============================================================================
// ubxfp_queue
// Short result queue that decouples the parser from the output side.
// ============================================================================
`default_nettype none

module ubxfp_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ubxfp_pkg::queue_ctl_t   ctl,
    input  wire ubxfp_pkg::frame_rec_t   wr_rec,
    input  wire logic                    pop,
    output logic                         full,
    output logic                         not_empty,
    output ubxfp_pkg::frame_rec_t        rd_rec
);
    import ubxfp_pkg::*;

    frame_rec_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = ctl.push && !ctl.full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_rec;
    end

    assign rd_rec = mem[rd_ptr_reg];

endmodule

`default_nettype wire

[design/ubxfp_back.sv]
// ============================================================================
// ubxfp_back
// Output stage: forms result fields from the queued frame record.
// ============================================================================
`default_nettype none

module ubxfp_back (
    input  wire ubxfp_pkg::frame_rec_t   rec,
    input  wire logic                    rec_valid,
    output logic                         pop,
    ubxfp_res_if.source                  res
);
    import ubxfp_pkg::*;

    logic is_nav;

    assign is_nav    = (rec.status == ST_NAV);
    assign res.valid = rec_valid;
    assign pop       = rec_valid && res.ready;

    // Fill navigation fields only for a navigation fix frame
    always_comb
    begin
        res.frame_status     = rec.status;
        res.msg_class        = rec.msg_class;
        res.msg_id           = rec.msg_id;
        res.fix_good         = 1'b0;
        res.fix_kind         = 8'd0;
        res.sat_count        = 8'd0;
        res.longitude_raw    = 32'sd0;
        res.latitude_raw     = 32'sd0;
        res.height_mm        = 32'sd0;
        res.ground_speed_mms = 32'sd0;
        res.heading_raw      = 32'sd0;
        res.dilution_raw     = 16'd0;
        if (is_nav)
        begin
            res.fix_good         = rec.fix_ok && (rec.kind >= FIX_KIND_MIN);
            res.fix_kind         = rec.kind;
            res.sat_count        = rec.sats;
            res.longitude_raw    = $signed(rec.cap[CAP_LON]);
            res.latitude_raw     = $signed(rec.cap[CAP_LAT]);
            res.height_mm        = $signed(rec.cap[CAP_HEIGHT]);
            res.ground_speed_mms = $signed(rec.cap[CAP_SPEED]);
            res.heading_raw      = $signed(rec.cap[CAP_HEAD]);
            res.dilution_raw     = rec.dilution;
        end
    end

endmodule

`default_nettype wire

[design/ubx_frame_parser_top.sv]
// ============================================================================
// ubx_frame_parser_top
// Binary receiver frame parser with 8-bit Fletcher checksum check.
// ============================================================================
// The parser takes one received byte per clock cycle and produces at most one
// result per frame: good frame, navigation fix frame with its decoded fields,
// checksum error, or oversize frame dropped. A result is written to the queue
// as the byte that ends the frame is taken, and shows on the result channel
// once all earlier results are taken. Finished results wait in a two-entry
// queue, so the byte input keeps running while the result side stalls; the
// byte input stalls only when both queue entries hold results not yet taken.
// ============================================================================
`default_nettype none

module ubx_frame_parser_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ubxfp_byte_if.sink  rx,
    ubxfp_res_if.source res
);
    import ubxfp_pkg::*;

    queue_ctl_t q_ctl;
    frame_rec_t q_wr_rec;
    frame_rec_t q_rd_rec;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;

    ubxfp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_full (q_full),
        .q_ctl  (q_ctl),
        .q_rec  (q_wr_rec)
    );

    ubxfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (q_ctl),
        .wr_rec    (q_wr_rec),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_rec    (q_rd_rec)
    );

    ubxfp_back u_back (
        .rec       (q_rd_rec),
        .rec_valid (q_not_empty),
        .pop       (q_pop),
        .res       (res)
    );

endmodule

`default_nettype wire
